FILE: rtl/assert_macros.svh
// assertion macros shared by the duration text parser rtl
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define AST_PROP(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define AST_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define AST_PROP(name, clk, rst_n, prop, msg)
`define AST_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/dtp_pkg.sv
// shared types and constants of the duration text parser
// no dependencies
package dtp_pkg;

    localparam int unsigned NOW_W = 17;
    localparam int unsigned VAL_W = 31;
    localparam int unsigned SCL_W = 32;
    localparam int unsigned SUM_W = 36;

    localparam logic [VAL_W-1:0] SAT31 = 31'h7FFF_FFFF;
    localparam logic [SCL_W-1:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFS  = 8'h20;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef enum logic [1:0] {
        MODE_ABS   = 2'd0,
        MODE_UNIT  = 2'd1,
        MODE_SHORT = 2'd2
    } mode_t;

    // one finished string, as three addends plus the time of day
    typedef struct packed {
        logic             ok;
        mode_t            mode;
        logic [NOW_W-1:0] now_sec;
        logic [SCL_W-1:0] term0;
        logic [SCL_W-1:0] term1;
        logic [SCL_W-1:0] term2;
    } term_t;

endpackage

FILE: rtl/dtp_scan.sv
// byte scanner: input register, token accumulators and addend selection
// depends on dtp_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtp_scan #(
    parameter int unsigned MAX_LENGTH = 255,
    parameter int unsigned MAX_TOKENS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_char_code,
    input  logic                      s_last_char,
    input  logic [dtp_pkg::NOW_W-1:0] s_now_second_of_day,
    output logic                      a_vld,
    output dtp_pkg::term_t            a_data,
    input  logic                      a_ready
);

    localparam int unsigned BC_W = $clog2(MAX_LENGTH + 2);
    localparam int unsigned TC_W = $clog2(MAX_TOKENS + 2);
    localparam logic [BC_W-1:0] BC_MAX = BC_W'(MAX_LENGTH);
    localparam logic [TC_W-1:0] TC_MAX = TC_W'(MAX_TOKENS);
    localparam logic [TC_W-1:0] TC_ONE = TC_W'(1);
    localparam logic [TC_W-1:0] TC_TWO = TC_W'(2);
    localparam logic [TC_W-1:0] TC_THREE = TC_W'(3);

    // value*10 + inc, clipped at cap
    function automatic logic [31:0] mac10(input logic [31:0] base, input logic [14:0] inc,
                                          input logic [31:0] cap);
        logic [35:0] full;
        full = ({4'd0, base} << 3) + ({4'd0, base} << 1) + {21'd0, inc};
        return (full > {4'd0, cap}) ? cap : full[31:0];
    endfunction

    // input register
    logic                      in_vld_reg;
    logic [7:0]                char_reg;
    logic                      last_reg;
    logic [dtp_pkg::NOW_W-1:0] now_reg;
    logic                      in_take;

    // running state
    logic [30:0]     tv1_reg, tv1_next;
    logic [31:0]     tv60_reg, tv60_next;
    logic [31:0]     tv3600_reg, tv3600_next;
    logic [30:0]     bare_reg, bare_next;
    logic [TC_W-1:0] cnt_reg, cnt_next;
    logic            in_tok_reg, in_tok_next;
    logic            digit_reg, digit_next;
    logic            bad_reg, bad_next;
    logic [BC_W-1:0] bc_reg, bc_next;

    // first three tokens, kept at the scales they are used with
    logic [31:0] fv0_3600_reg, fv0_3600_next;
    logic [31:0] fv0_60_reg, fv0_60_next;
    logic [31:0] fv1_60_reg, fv1_60_next;
    logic [30:0] fv1_1_reg, fv1_1_next;
    logic [30:0] fv2_1_reg, fv2_1_next;

    logic           a_vld_reg;
    dtp_pkg::term_t a_data_reg;
    dtp_pkg::term_t term_next;
    logic           a_free;

    logic [7:0]      lc;
    logic            is_digit, is_space;
    logic            sfx_h, sfx_m, sfx_s, sfx_t, is_sfx;
    logic [3:0]      dig;
    logic [30:0]     base1;
    logic [31:0]     base60, base3600;
    logic [TC_W-1:0] close_idx;
    logic [32:0]     bare_add;

    logic            tok_open, captured;
    logic [TC_W-1:0] cnt_u, n_used;
    logic [31:0]     sfx_val;
    logic [31:0]     fv0_3600_e, fv0_60_e, fv1_60_e;
    logic [30:0]     fv1_1_e, fv2_1_e;

    assign a_free  = !a_vld_reg || a_ready;
    assign in_take = in_vld_reg && (!last_reg || a_free);
    assign s_ready = !in_vld_reg || in_take;
    assign a_vld   = a_vld_reg;
    assign a_data  = a_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_char_code;
            last_reg <= s_last_char;
            now_reg  <= s_now_second_of_day;
        end
    end

    // byte decode
    always_comb begin
        lc = ((char_reg >= dtp_pkg::CH_UP_A) && (char_reg <= dtp_pkg::CH_UP_Z)) ?
             (char_reg + dtp_pkg::CASE_OFS) : char_reg;
        is_digit = (char_reg >= dtp_pkg::CH_0) && (char_reg <= dtp_pkg::CH_9);
        is_space = (char_reg == dtp_pkg::CH_SPACE);
        sfx_h    = last_reg && (lc == dtp_pkg::CH_H);
        sfx_m    = last_reg && (lc == dtp_pkg::CH_M);
        sfx_s    = last_reg && (lc == dtp_pkg::CH_S);
        sfx_t    = last_reg && (lc == dtp_pkg::CH_T);
        is_sfx   = sfx_h || sfx_m || sfx_s || sfx_t;
        dig      = char_reg[3:0];
    end

    // state update for one beat
    always_comb begin
        tv1_next      = tv1_reg;
        tv60_next     = tv60_reg;
        tv3600_next   = tv3600_reg;
        bare_next     = bare_reg;
        cnt_next      = cnt_reg;
        in_tok_next   = in_tok_reg;
        digit_next    = digit_reg;
        bad_next      = bad_reg;
        fv0_3600_next = fv0_3600_reg;
        fv0_60_next   = fv0_60_reg;
        fv1_60_next   = fv1_60_reg;
        fv1_1_next    = fv1_1_reg;
        fv2_1_next    = fv2_1_reg;
        bc_next       = (bc_reg <= BC_MAX) ? (bc_reg + 1'b1) : bc_reg;

        base1     = in_tok_reg ? tv1_reg : '0;
        base60    = in_tok_reg ? tv60_reg : '0;
        base3600  = in_tok_reg ? tv3600_reg : '0;
        close_idx = cnt_reg - 1'b1;
        bare_add  = {2'b00, bare_reg} + {1'b0, tv60_reg};

        if (is_digit) begin
            if (!in_tok_reg && (cnt_reg <= TC_MAX)) begin
                cnt_next = cnt_reg + 1'b1;
            end
            tv1_next    = 31'(mac10({1'b0, base1}, {11'd0, dig}, {1'b0, dtp_pkg::SAT31}));
            tv60_next   = mac10(base60, {11'd0, dig} * 15'(dtp_pkg::SEC_PER_MIN),
                                dtp_pkg::SAT32);
            tv3600_next = mac10(base3600, {11'd0, dig} * 15'(dtp_pkg::SEC_PER_HOUR),
                                dtp_pkg::SAT32);
            in_tok_next = 1'b1;
            digit_next  = 1'b1;
        end else if (is_space) begin
            if (in_tok_reg) begin
                in_tok_next = 1'b0;
                if (close_idx == '0) begin
                    fv0_3600_next = tv3600_reg;
                    fv0_60_next   = tv60_reg;
                end
                if (close_idx == TC_ONE) begin
                    fv1_60_next = tv60_reg;
                    fv1_1_next  = tv1_reg;
                end
                if (close_idx == TC_TWO) begin
                    fv2_1_next = tv1_reg;
                end
                if (close_idx < TC_MAX) begin
                    bare_next = (bare_add > {2'b00, dtp_pkg::SAT31}) ?
                                dtp_pkg::SAT31 : bare_add[30:0];
                end
            end
        end else if (!is_sfx) begin
            bad_next = 1'b1;
        end
    end

    // end of string: pick the addends for the final sum
    always_comb begin
        tok_open = !in_tok_next;
        cnt_u    = (tok_open && (cnt_next <= TC_MAX)) ? (cnt_next + 1'b1) : cnt_next;
        captured = (cnt_u <= TC_MAX);
        n_used   = captured ? cnt_u : TC_MAX;

        if (!captured || tok_open) begin
            sfx_val = '0;
        end else if (sfx_h) begin
            sfx_val = tv3600_next;
        end else if (sfx_m) begin
            sfx_val = tv60_next;
        end else begin
            sfx_val = {1'b0, tv1_next};
        end

        // an open token is closed into the first values before use
        fv0_3600_e = (in_tok_next && (cnt_next == TC_ONE)) ? tv3600_next : fv0_3600_next;
        fv0_60_e   = (in_tok_next && (cnt_next == TC_ONE)) ? tv60_next : fv0_60_next;
        fv1_60_e   = (in_tok_next && (cnt_next == TC_TWO)) ? tv60_next : fv1_60_next;
        fv1_1_e    = (in_tok_next && (cnt_next == TC_TWO)) ? tv1_next : fv1_1_next;
        fv2_1_e    = (in_tok_next && (cnt_next == TC_THREE)) ? tv1_next : fv2_1_next;

        term_next.ok      = !bad_next && digit_next && (bc_next <= BC_MAX);
        term_next.now_sec = now_reg;
        term_next.mode    = dtp_pkg::MODE_SHORT;
        term_next.term0   = '0;
        term_next.term1   = '0;
        term_next.term2   = '0;

        priority if (sfx_h || sfx_m || sfx_s) begin
            term_next.mode = dtp_pkg::MODE_UNIT;
            priority if (n_used == TC_TWO) begin
                term_next.term0 = fv0_60_next;
                term_next.term1 = sfx_val;
            end else if (n_used == TC_THREE) begin
                term_next.term0 = fv0_3600_next;
                term_next.term1 = fv1_60_next;
                term_next.term2 = captured ? sfx_val : {1'b0, fv2_1_next};
            end else begin
                term_next.term0 = {1'b0, bare_next};
                term_next.term1 = sfx_val;
            end
        end else if (sfx_t) begin
            term_next.mode  = dtp_pkg::MODE_ABS;
            term_next.term0 = fv0_3600_e;
            term_next.term1 = (cnt_next >= TC_TWO) ? fv1_60_e : '0;
            term_next.term2 = (cnt_next >= TC_THREE) ? {1'b0, fv2_1_e} : '0;
        end else begin
            priority if (cnt_next >= TC_THREE) begin
                term_next.term0 = fv0_3600_e;
                term_next.term1 = fv1_60_e;
                term_next.term2 = {1'b0, fv2_1_e};
            end else if (cnt_next == TC_TWO) begin
                term_next.term0 = fv0_60_e;
                term_next.term1 = {1'b0, fv1_1_e};
            end else if (cnt_next == TC_ONE) begin
                term_next.term0 = fv0_60_e;
            end else begin
                term_next.term0 = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv1_reg    <= '0;
            tv60_reg   <= '0;
            tv3600_reg <= '0;
            bare_reg   <= '0;
            cnt_reg    <= '0;
            in_tok_reg <= 1'b0;
            digit_reg  <= 1'b0;
            bad_reg    <= 1'b0;
            bc_reg     <= '0;
        end else if (in_take) begin
            if (last_reg) begin
                tv1_reg    <= '0;
                tv60_reg   <= '0;
                tv3600_reg <= '0;
                bare_reg   <= '0;
                cnt_reg    <= '0;
                in_tok_reg <= 1'b0;
                digit_reg  <= 1'b0;
                bad_reg    <= 1'b0;
                bc_reg     <= '0;
            end else begin
                tv1_reg    <= tv1_next;
                tv60_reg   <= tv60_next;
                tv3600_reg <= tv3600_next;
                bare_reg   <= bare_next;
                cnt_reg    <= cnt_next;
                in_tok_reg <= in_tok_next;
                digit_reg  <= digit_next;
                bad_reg    <= bad_next;
                bc_reg     <= bc_next;
            end
        end
    end

    // written before read within every string, so no reset
    always_ff @(posedge aclk) begin
        if (in_take) begin
            fv0_3600_reg <= fv0_3600_next;
            fv0_60_reg   <= fv0_60_next;
            fv1_60_reg   <= fv1_60_next;
            fv1_1_reg    <= fv1_1_next;
            fv2_1_reg    <= fv2_1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_free) begin
            a_vld_reg <= in_take && last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && last_reg) begin
            a_data_reg <= term_next;
        end
    end

    `AST_PROP(a_cnt_range, aclk, aresetn, cnt_reg <= TC_W'(MAX_TOKENS + 1), "token count overrun")
    `AST_NEVER(a_bc_range, aclk, aresetn, bc_reg > BC_W'(MAX_LENGTH + 1), "byte count overrun")
    `AST_PROP(a_tok_digit, aclk, aresetn, in_tok_reg |-> digit_reg, "token open without digit")
    `AST_PROP(a_clear_after_last, aclk, aresetn, in_take && last_reg |=> (cnt_reg == '0) && !in_tok_reg && (bc_reg == '0), "state not cleared after last beat")
    `AST_PROP(a_hold_stage, aclk, aresetn, a_vld_reg && !a_ready |=> a_vld_reg && $stable(a_data_reg), "addend stage lost while stalled")

endmodule

FILE: rtl/dtp_resolve.sv
// final sum, time-of-day wrap, saturation and result register
// depends on dtp_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtp_resolve (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      a_vld,
    input  dtp_pkg::term_t            a_data,
    output logic                      a_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_valid_res,
    output logic [dtp_pkg::VAL_W-1:0] m_duration_sec,
    output logic [1:0]                m_parse_mode
);

    localparam int unsigned SW = dtp_pkg::SUM_W;

    logic          b_vld_reg;
    logic          b_ok_reg;
    dtp_pkg::mode_t b_mode_reg;
    logic [SW-1:0] b_sum_reg;
    logic [SW-1:0] b_sum_next;
    logic          b_ready;
    logic          a_abs;

    logic          m_valid_reg;
    logic          m_valid_res_reg;
    logic [dtp_pkg::VAL_W-1:0] m_total_reg;
    logic [1:0]    m_mode_reg;

    logic          b_abs;
    logic          nonpos;
    logic [SW-1:0] fin;
    logic          fin_pos;
    logic [dtp_pkg::VAL_W-1:0] fin_sat;
    logic          res_ok;

    assign b_ready = !m_valid_reg || m_ready;
    assign a_ready = !b_vld_reg || b_ready;

    // absolute mode subtracts now here; the sign is checked in the next stage
    assign a_abs      = (a_data.mode == dtp_pkg::MODE_ABS);
    assign b_sum_next = SW'(a_data.term0) + SW'(a_data.term1) + SW'(a_data.term2)
                      - (a_abs ? SW'(a_data.now_sec) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (a_ready) begin
            b_vld_reg <= a_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_vld) begin
            b_ok_reg   <= a_data.ok;
            b_mode_reg <= a_data.mode;
            b_sum_reg  <= b_sum_next;
        end
    end

    always_comb begin
        b_abs   = (b_mode_reg == dtp_pkg::MODE_ABS);
        nonpos  = b_sum_reg[SW-1] || (b_sum_reg == '0);
        // target not later than now: same time tomorrow
        fin     = (b_abs && nonpos) ? (b_sum_reg + SW'(dtp_pkg::SEC_PER_DAY)) : b_sum_reg;
        fin_pos = !fin[SW-1] && (fin != '0);
        fin_sat = (fin > SW'(dtp_pkg::SAT31)) ? dtp_pkg::SAT31 : fin[dtp_pkg::VAL_W-1:0];
        res_ok  = b_ok_reg && fin_pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_ready) begin
            m_valid_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && b_vld_reg) begin
            m_valid_res_reg <= res_ok;
            m_total_reg     <= res_ok ? fin_sat : '0;
            m_mode_reg      <= res_ok ? b_mode_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_valid_res    = m_valid_res_reg;
    assign m_duration_sec = m_total_reg;
    assign m_parse_mode   = m_mode_reg;

    `AST_PROP(a_res_nonzero, aclk, aresetn, m_valid_reg && m_valid_res_reg |-> m_total_reg != '0, "valid result of zero seconds")
    `AST_PROP(a_res_cleared, aclk, aresetn, m_valid_reg && !m_valid_res_reg |-> (m_total_reg == '0) && (m_mode_reg == '0), "invalid result carries data")
    `AST_PROP(a_sum_hold, aclk, aresetn, b_vld_reg && !b_ready |=> b_vld_reg && $stable(b_sum_reg), "sum stage lost while stalled")
    `AST_PROP(a_sum_moves, aclk, aresetn, b_vld_reg && b_ready |=> m_valid_reg, "sum stage result dropped")

endmodule

FILE: rtl/duration_text_parser_core.sv
// top level of the duration text parser: byte scanner plus result stage
// depends on dtp_pkg, dtp_scan and dtp_resolve
//
//  channel  | direction | ports                                         | handshake
//  ---------+-----------+-----------------------------------------------+----------------
//  s_ input | in        | s_char_code, s_last_char, s_now_second_of_day | s_valid/s_ready
//  m_ result| out       | m_valid_res, m_duration_sec, m_parse_mode     | m_valid/m_ready
//
// one byte beat per cycle sustained while no last byte waits; only the beat flagged last yields a result beat
// once its last byte is accepted, a result passes from the input register through the addend,
// sum and output registers in that order
// synchronous active-low reset clears control state; no clearing pass
// while the result path is full other bytes keep being taken; a last byte waits in
// the input register until the addend register frees
module duration_text_parser_core #(
    parameter int unsigned MAX_LENGTH = 255,
    parameter int unsigned MAX_TOKENS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_char_code,
    input  logic                      s_last_char,
    input  logic [dtp_pkg::NOW_W-1:0] s_now_second_of_day,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_valid_res,
    output logic [dtp_pkg::VAL_W-1:0] m_duration_sec,
    output logic [1:0]                m_parse_mode
);

    logic           a_vld;
    logic           a_ready;
    dtp_pkg::term_t a_data;

    dtp_scan #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_scan (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_char_code         (s_char_code),
        .s_last_char         (s_last_char),
        .s_now_second_of_day (s_now_second_of_day),
        .a_vld               (a_vld),
        .a_data              (a_data),
        .a_ready             (a_ready)
    );

    dtp_resolve u_resolve (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .a_vld          (a_vld),
        .a_data         (a_data),
        .a_ready        (a_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_duration_sec (m_duration_sec),
        .m_parse_mode   (m_parse_mode)
    );

endmodule

FILE: sim/testbench.sv
// self-checking testbench for duration_text_parser_core
// depends on dtp_pkg and the rtl top level; a directed table followed by random strings,
// each result beat is checked against its table row or a behavioral parser in this file
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_LEN     = 255;
    localparam int MAX_TOK     = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BYTES = 220;
    localparam logic [7:0] NO_SUFFIX = 8'h00;
    localparam logic [63:0] HOUR_64 = 64'(dtp_pkg::SEC_PER_HOUR);
    localparam logic [63:0] MIN_64  = 64'(dtp_pkg::SEC_PER_MIN);
    localparam logic [63:0] DAY_64  = 64'(dtp_pkg::SEC_PER_DAY);

    typedef struct packed {
        logic                      ok;
        logic [dtp_pkg::VAL_W-1:0] secs;
        dtp_pkg::mode_t            mode;
    } duration_t;

    typedef struct {
        int                        first;
        int                        len;
        logic [dtp_pkg::NOW_W-1:0] tod;
        bit                        typed;
        duration_t                 want;
    } probe_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_char_code = 8'h00;
    logic                      s_last_char = 1'b0;
    logic [dtp_pkg::NOW_W-1:0] s_now_second_of_day = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_valid_res;
    logic [dtp_pkg::VAL_W-1:0] m_duration_sec;
    logic [1:0]                m_parse_mode;

    duration_text_parser_core DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_char_code         (s_char_code),
        .s_last_char         (s_last_char),
        .s_now_second_of_day (s_now_second_of_day),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_valid_res         (m_valid_res),
        .m_duration_sec      (m_duration_sec),
        .m_parse_mode        (m_parse_mode)
    );

    always #1 aclk = ~aclk;

    // parser state mirrored from the block
    logic [dtp_pkg::VAL_W-1:0] tok_val;
    logic [dtp_pkg::VAL_W-1:0] head_vals [3];
    logic [3:0]                tok_cnt;
    logic [dtp_pkg::VAL_W-1:0] minute_sum;
    bit                        in_tok;
    bit                        saw_digit;
    bit                        text_bad;
    logic [8:0]                len_cnt;

    duration_t    durations_due [$];
    logic [7:0]   word_q [$];
    logic [7:0]   dir_bytes [$];
    probe_row_t   probe_rows [$];
    int           row_start = 0;
    int           mismatches = 0;
    int           random_bytes = 0;
    int           feed_gap_pct = 0;
    int           sink_stall_pct = 0;
    int           idle_cycles = 0;

    function automatic logic [dtp_pkg::VAL_W-1:0] clip31(input logic [63:0] x);
        return (x > 64'(dtp_pkg::SAT31)) ? dtp_pkg::SAT31 : x[dtp_pkg::VAL_W-1:0];
    endfunction

    function automatic void clear_parser();
        tok_val = '0;
        head_vals[0] = '0;
        head_vals[1] = '0;
        head_vals[2] = '0;
        tok_cnt = '0;
        minute_sum = '0;
        in_tok = 1'b0;
        saw_digit = 1'b0;
        text_bad = 1'b0;
        len_cnt = '0;
    endfunction

    function automatic void open_tok();
        if (tok_cnt <= MAX_TOK) tok_cnt++;
        tok_val = '0;
        in_tok = 1'b1;
    endfunction

    function automatic void close_tok();
        int idx;
        logic [63:0] sum;
        idx = int'(tok_cnt) - 1;
        if (idx < 3) head_vals[idx] = tok_val;
        if (idx < MAX_TOK) begin
            sum = 64'(minute_sum) + 64'(tok_val) * MIN_64;
            minute_sum = clip31(sum);
        end
        in_tok = 1'b0;
    endfunction

    // one byte into the parser; returns 1 when a duration comes out
    function automatic bit parse_char(input logic [7:0] c, input bit is_last,
                                      input logic [dtp_pkg::NOW_W-1:0] tod,
                                      output duration_t res);
        logic [7:0]  lc;
        logic [7:0]  sfx;
        logic [63:0] acc;
        logic [63:0] total;
        logic [63:0] unit;
        logic [63:0] sfx_val;
        logic [63:0] tgt;
        logic [dtp_pkg::VAL_W-1:0] secs;
        int          n;
        int          cnt;
        bit          ok;
        bit          captured;
        dtp_pkg::mode_t mode;
        lc = (c >= dtp_pkg::CH_UP_A && c <= dtp_pkg::CH_UP_Z) ? c + dtp_pkg::CASE_OFS : c;
        sfx = NO_SUFFIX;
        total = '0;
        mode = dtp_pkg::MODE_ABS;
        res = '0;
        if (len_cnt <= MAX_LEN) len_cnt++;

        if (c >= dtp_pkg::CH_0 && c <= dtp_pkg::CH_9) begin
            if (!in_tok) open_tok();
            acc = 64'(tok_val) * 64'd10 + 64'(c - dtp_pkg::CH_0);
            tok_val = clip31(acc);
            saw_digit = 1'b1;
        end else if (c == dtp_pkg::CH_SPACE) begin
            if (in_tok) close_tok();
        end else if (is_last && (lc == dtp_pkg::CH_H || lc == dtp_pkg::CH_M ||
                                 lc == dtp_pkg::CH_S || lc == dtp_pkg::CH_T)) begin
            sfx = lc;
        end else begin
            text_bad = 1'b1;
        end

        if (!is_last) return 1'b0;

        ok = !text_bad && saw_digit && (len_cnt <= MAX_LEN);
        if (ok) begin
            if (sfx == dtp_pkg::CH_H || sfx == dtp_pkg::CH_M || sfx == dtp_pkg::CH_S) begin
                mode = dtp_pkg::MODE_UNIT;
                unit = (sfx == dtp_pkg::CH_H) ? HOUR_64 :
                       (sfx == dtp_pkg::CH_M) ? MIN_64 : 64'd1;
                // a lone suffix after a space still opens a token of value zero
                if (!in_tok) open_tok();
                captured = (tok_cnt <= MAX_TOK);
                n = captured ? int'(tok_cnt) : MAX_TOK;
                sfx_val = captured ? 64'(tok_val) * unit : 64'd0;
                if (n == 2)
                    total = 64'(head_vals[0]) * MIN_64 + sfx_val;
                else if (n == 3)
                    total = 64'(head_vals[0]) * HOUR_64 + 64'(head_vals[1]) * MIN_64
                          + sfx_val;
                else
                    total = 64'(minute_sum) + sfx_val;
            end else begin
                if (in_tok) close_tok();
                cnt = (tok_cnt > 3) ? 3 : int'(tok_cnt);
                if (sfx == dtp_pkg::CH_T) begin
                    mode = dtp_pkg::MODE_ABS;
                    tgt = 64'(head_vals[0]) * HOUR_64;
                    if (cnt >= 2) tgt += 64'(head_vals[1]) * MIN_64;
                    if (cnt >= 3) tgt += 64'(head_vals[2]);
                    if (tgt <= 64'(tod)) tgt += DAY_64;
                    total = (tgt > 64'(tod)) ? tgt - 64'(tod) : 64'd0;
                end else begin
                    mode = dtp_pkg::MODE_SHORT;
                    if (cnt == 1)
                        total = 64'(head_vals[0]) * MIN_64;
                    else if (cnt == 2)
                        total = 64'(head_vals[0]) * MIN_64 + 64'(head_vals[1]);
                    else if (cnt == 3)
                        total = 64'(head_vals[0]) * HOUR_64 + 64'(head_vals[1]) * MIN_64
                              + 64'(head_vals[2]);
                end
            end
            secs = clip31(total);
            if (secs == '0) ok = 1'b0;
        end else begin
            secs = '0;
        end

        res.ok = ok;
        res.secs = ok ? secs : '0;
        res.mode = ok ? mode : dtp_pkg::MODE_ABS;
        clear_parser();
        return 1'b1;
    endfunction

    // directed table construction
    function automatic void put_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++) dir_bytes.push_back(text[i]);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        dir_bytes.push_back(b);
    endfunction

    function automatic void end_row(input logic [dtp_pkg::NOW_W-1:0] tod, input bit typed,
                                    input logic ok, input logic [dtp_pkg::VAL_W-1:0] secs,
                                    input dtp_pkg::mode_t mode);
        probe_row_t r;
        r.first = row_start;
        r.len = dir_bytes.size() - row_start;
        r.tod = tod;
        r.typed = typed;
        r.want.ok = ok;
        r.want.secs = secs;
        r.want.mode = mode;
        probe_rows.push_back(r);
        row_start = dir_bytes.size();
    endfunction

    function automatic void fill_probe_table();
        int i;
        put_text("90");          end_row(0, 1, 1, 5400, dtp_pkg::MODE_SHORT);
        put_text("1 30");        end_row(0, 1, 1, 90, dtp_pkg::MODE_SHORT);
        put_text("1 2 3");       end_row(0, 1, 1, 3723, dtp_pkg::MODE_SHORT);
        put_text(" 1 2 3 4 ");   end_row(0, 0, 0, 0, dtp_pkg::MODE_ABS);
        put_text("0");           end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        put_text(" ");           end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        put_text("5h");          end_row(0, 1, 1, 18000, dtp_pkg::MODE_UNIT);
        put_text("5M");          end_row(0, 1, 1, 300, dtp_pkg::MODE_UNIT);
        put_text("45s");         end_row(0, 1, 1, 45, dtp_pkg::MODE_UNIT);
        put_text("1 30m");       end_row(0, 0, 0, 0, dtp_pkg::MODE_ABS);
        put_text("1 2 3S");      end_row(0, 0, 0, 0, dtp_pkg::MODE_ABS);
        put_text("1 2 3 4m");    end_row(0, 0, 0, 0, dtp_pkg::MODE_ABS);
        // suffixed token past the token limit
        put_text("1 2 3 4 5 6 7 8 9 10 11h"); end_row(0, 0, 0, 0, dtp_pkg::MODE_ABS);
        put_text("5 m");         end_row(0, 0, 0, 0, dtp_pkg::MODE_ABS);
        put_text("h");           end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        put_text("7t");          end_row(0, 1, 1, 25200, dtp_pkg::MODE_ABS);
        put_text("7 30T");       end_row(28000, 0, 0, 0, dtp_pkg::MODE_ABS);
        // target equal to the time of day rolls to the next day
        put_text("12 0 0t");     end_row(43200, 1, 1, 86400, dtp_pkg::MODE_ABS);
        put_text("25t");         end_row(86399, 0, 0, 0, dtp_pkg::MODE_ABS);
        put_text("99999999999"); end_row(0, 1, 1, dtp_pkg::SAT31, dtp_pkg::MODE_SHORT);
        put_text("2147483647h"); end_row(0, 1, 1, dtp_pkg::SAT31, dtp_pkg::MODE_UNIT);
        put_text("1x2");         end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        put_text("1h2");         end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        put_text("1");
        put_byte(8'h00);         end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        put_byte(8'hFF);
        put_text("1");           end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        // longest legal string, then one byte too many
        put_text("1");
        for (i = 1; i < MAX_LEN; i++) put_byte(dtp_pkg::CH_SPACE);
        end_row(0, 1, 1, 60, dtp_pkg::MODE_SHORT);
        put_text("1");
        for (i = 1; i <= MAX_LEN; i++) put_byte(dtp_pkg::CH_SPACE);
        end_row(0, 1, 0, 0, dtp_pkg::MODE_ABS);
        // time of day beyond one day leaves nothing to wait for
        put_text("0t");          end_row(17'h1FFFF, 1, 0, 0, dtp_pkg::MODE_ABS);
    endfunction

    task automatic push_byte(input logic [7:0] c, input bit is_last,
                             input logic [dtp_pkg::NOW_W-1:0] tod, input bit typed,
                             input duration_t want);
        duration_t got;
        @(negedge aclk);
        while ($urandom_range(99) < feed_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        s_last_char <= is_last;
        s_now_second_of_day <= tod;
        do @(posedge aclk); while (!s_ready);
        if (parse_char(c, is_last, tod, got))
            durations_due.push_back(typed ? want : got);
        random_bytes++;
    endtask

    task automatic send_text(input logic [dtp_pkg::NOW_W-1:0] tod, input bit typed,
                             input duration_t want);
        int i;
        for (i = 0; i < word_q.size(); i++)
            push_byte(word_q[i], i == word_q.size() - 1, tod, typed, want);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (durations_due.size() != 0) @(posedge aclk);
    endtask

    task automatic make_random_text();
        int kind;
        int ntok;
        int ndig;
        int pick;
        int i;
        int j;
        logic [7:0] sfx;
        word_q.delete();
        kind = $urandom_range(99);
        if (kind == 0) begin
            // around the length limit
            word_q.push_back(dtp_pkg::CH_0 + 8'($urandom_range(9, 1)));
            ntok = $urandom_range(258, 252);
            while (word_q.size() < ntok) word_q.push_back(dtp_pkg::CH_SPACE);
        end else if (kind < 75) begin
            if ($urandom_range(7) == 0) word_q.push_back(dtp_pkg::CH_SPACE);
            ntok = ($urandom_range(4) == 0) ? $urandom_range(13, 4) : $urandom_range(3, 1);
            for (i = 0; i < ntok; i++) begin
                if (i > 0) begin
                    word_q.push_back(dtp_pkg::CH_SPACE);
                    if ($urandom_range(5) == 0) word_q.push_back(dtp_pkg::CH_SPACE);
                end
                ndig = ($urandom_range(19) == 0) ? $urandom_range(12, 6) : $urandom_range(2, 1);
                for (j = 0; j < ndig; j++)
                    word_q.push_back(dtp_pkg::CH_0 + 8'($urandom_range(9)));
            end
            pick = $urandom_range(5);
            if (pick >= 2) begin
                if ($urandom_range(5) == 0) word_q.push_back(dtp_pkg::CH_SPACE);
                sfx = (pick == 2) ? dtp_pkg::CH_H : (pick == 3) ? dtp_pkg::CH_M
                    : (pick == 4) ? dtp_pkg::CH_S : dtp_pkg::CH_T;
                if ($urandom_range(1)) sfx = sfx - dtp_pkg::CASE_OFS;
                word_q.push_back(sfx);
            end else if ($urandom_range(5) == 0) begin
                word_q.push_back(dtp_pkg::CH_SPACE);
            end
        end else if (kind < 88) begin
            // digits broken by one stray byte, often a misplaced suffix
            ndig = $urandom_range(3, 1);
            for (j = 0; j < ndig; j++)
                word_q.push_back(dtp_pkg::CH_0 + 8'($urandom_range(9)));
            pick = $urandom_range(4);
            sfx = (pick == 0) ? dtp_pkg::CH_H : (pick == 1) ? dtp_pkg::CH_M
                : (pick == 2) ? dtp_pkg::CH_T : 8'($urandom_range(255));
            word_q.push_back(sfx);
            ndig = $urandom_range(2);
            for (j = 0; j < ndig; j++)
                word_q.push_back(dtp_pkg::CH_0 + 8'($urandom_range(9)));
            if ($urandom_range(1)) word_q.push_back(dtp_pkg::CH_S);
        end else begin
            ndig = $urandom_range(6, 1);
            for (j = 0; j < ndig; j++) word_q.push_back(8'($urandom_range(255)));
        end
    endtask

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge aclk) begin : result_check
        duration_t want;
        if (aresetn && m_valid && m_ready) begin
            if (durations_due.size() == 0) begin
                $error("m_valid: result beat with no duration pending");
                mismatches++;
            end else begin
                want = durations_due.pop_front();
                if (m_valid_res !== want.ok) begin
                    $error("valid_res: expected %0d, got %0d", want.ok, m_valid_res);
                    mismatches++;
                end
                if (m_duration_sec !== want.secs) begin
                    $error("duration_sec: expected %0d, got %0d", want.secs, m_duration_sec);
                    mismatches++;
                end
                if (m_parse_mode !== want.mode) begin
                    $error("parse_mode: expected %0d, got %0d", want.mode, m_parse_mode);
                    mismatches++;
                end
            end
        end
    end

    // no beat moving on either side for too long means the block is hung
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int k;
        int phase;
        duration_t none;
        none = '0;
        clear_parser();
        fill_probe_table();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < probe_rows.size(); r++) begin
            word_q.delete();
            for (k = 0; k < probe_rows[r].len; k++)
                word_q.push_back(dir_bytes[probe_rows[r].first + k]);
            send_text(probe_rows[r].tod, probe_rows[r].typed, probe_rows[r].want);
        end
        drain_results();

        random_bytes = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin feed_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin feed_gap_pct = 51; sink_stall_pct = 0;  end
                2: begin feed_gap_pct = 0;  sink_stall_pct = 51; end
                default: begin feed_gap_pct = 9; sink_stall_pct = 9; end
            endcase
            while (random_bytes < (phase + 1) * RANDOM_BYTES / 4) begin
                make_random_text();
                send_text($urandom_range(86399), 1'b0, none);
            end
            // hold the input until every pending duration is out
            drain_results();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: duration_text_parser_core.f
+incdir+rtl
rtl/dtp_pkg.sv
rtl/dtp_scan.sv
rtl/dtp_resolve.sv
rtl/duration_text_parser_core.sv
sim/testbench.sv
